[rtl/core/ssi_pkg.sv]
`timescale 1ns / 1ps

package ssi_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;

    // input item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD_FIRST  = 2'd0,
        OP_LOAD_SECOND = 2'd1,
        OP_RUN         = 2'd2
    } t_op;

    // control states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FLUSH
    } t_state;

endpackage

[rtl/core/ssi_if.sv]
`timescale 1ns / 1ps

// input channel: load and run items
interface ssi_in_if;
    logic                               valid;
    logic                               ready;
    logic [ssi_pkg::OP_W-1:0]           op;
    logic signed [ssi_pkg::VAL_W-1:0]   value;

    modport source (output valid, op, value, input ready);
    modport sink   (input valid, op, value, output ready);
endinterface

// output channel: intersection results
interface ssi_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ssi_pkg::VAL_W-1:0]   common_value;
    logic                               last;
    logic                               empty_res;
    logic                               dropped;

    modport source (output valid, common_value, last, empty_res, dropped, input ready);
    modport sink   (input valid, common_value, last, empty_res, dropped, output ready);
endinterface

[rtl/core/ssi_ram.sv]
`timescale 1ns / 1ps

module ssi_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[rtl/core/sorted_set_intersection_unit.sv]
`timescale 1ns / 1ps

// Sorted set intersection unit.
// Input channel i_in carries items of two kinds: loads (op 0 into the first
// list, op 1 into the second list) append one signed 32-bit value, and a run
// (op 2) walks both ascending lists with two pointers. Op 3 is ignored.
// Output channel o_out gives one item per matched pair in walk order; the
// final item of a run has last set. An empty intersection gives one item
// with empty_res set and value zero. Every run item carries dropped, set when
// a load since the last run found its list full.
// A load or an ignored item is taken in ST_IDLE. A run repeats a walk step
// (ST_READ for the synchronous read of both list memories, then ST_CMP for
// the compare and pointer update), at most first_count + second_count steps,
// then finishes in ST_FLUSH; the next item is taken after the final result
// is in the output register. A match waits for its predecessor to go out, so
// results need a lookahead of one held match; a stalled receiver holds the
// walk at the next match. Reset clears both counts, the dropped flag, the held
// match and the output valid flag; list contents are undefined until loaded.

module sorted_set_intersection_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ssi_in_if.sink   i_in,
    ssi_out_if.source o_out
);

    import ssi_pkg::*;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0] r_cnt_b, n_cnt_b;
    logic             r_drop,  n_drop;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;

    logic             r_pend_valid, n_pend_valid;
    logic [VAL_W-1:0] r_pend_val,   n_pend_val;

    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_val,   n_out_val;
    logic             r_out_last,  n_out_last;
    logic             r_out_empty, n_out_empty;
    logic             r_out_drop,  n_out_drop;

    logic             we_a, we_b;
    logic [VAL_W-1:0] rdata_a, rdata_b;
    logic             out_free;
    logic             in_fire;
    t_op              in_op;
    logic [CNT_W-1:0] i_inc, j_inc;
    logic             a_lt_b, a_gt_b;
    logic             match_stall;

    // list memories
    ssi_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_i[IDX_W-1:0]),
        .o_rdata (rdata_a)
    );

    ssi_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_j[IDX_W-1:0]),
        .o_rdata (rdata_b)
    );

    // handshake and compare helpers
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign in_op       = t_op'(i_in.op);
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_inc       = r_i + CNT_W'(1);
    assign j_inc       = r_j + CNT_W'(1);
    assign a_lt_b      = $signed(rdata_a) < $signed(rdata_b);
    assign a_gt_b      = $signed(rdata_a) > $signed(rdata_b);
    assign match_stall = !a_lt_b && !a_gt_b && r_pend_valid && !out_free;

    assign we_a = in_fire && (in_op == OP_LOAD_FIRST)  && (r_cnt_a < CNT_W'(CAPACITY));
    assign we_b = in_fire && (in_op == OP_LOAD_SECOND) && (r_cnt_b < CNT_W'(CAPACITY));

    assign o_out.valid        = r_out_valid;
    assign o_out.common_value = r_out_val;
    assign o_out.last         = r_out_last;
    assign o_out.empty_res    = r_out_empty;
    assign o_out.dropped      = r_out_drop;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && in_op == OP_RUN) begin
                    if (r_cnt_a == '0 || r_cnt_b == '0) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (a_lt_b) begin
                    n_state = (i_inc == r_cnt_a) ? ST_FLUSH : ST_READ;
                end else if (a_gt_b) begin
                    n_state = (j_inc == r_cnt_b) ? ST_FLUSH : ST_READ;
                end else if (!match_stall) begin
                    n_state = (i_inc == r_cnt_a || j_inc == r_cnt_b) ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_drop       = r_drop;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_valid = r_pend_valid;
        n_pend_val   = r_pend_val;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_val    = r_out_val;
        n_out_last   = r_out_last;
        n_out_empty  = r_out_empty;
        n_out_drop   = r_out_drop;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (in_op)
                        OP_LOAD_FIRST: begin
                            if (we_a) begin
                                n_cnt_a = r_cnt_a + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_LOAD_SECOND: begin
                            if (we_b) begin
                                n_cnt_b = r_cnt_b + CNT_W'(1);
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        OP_RUN: begin
                            n_i = '0;
                            n_j = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP: begin
                if (a_lt_b) begin
                    n_i = i_inc;
                end else if (a_gt_b) begin
                    n_j = j_inc;
                end else if (!match_stall) begin
                    // push the held match out, hold the new one
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_val   = r_pend_val;
                        n_out_last  = 1'b0;
                        n_out_empty = 1'b0;
                        n_out_drop  = r_drop;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_val   = rdata_a;
                    n_i          = i_inc;
                    n_j          = j_inc;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_val    = r_pend_valid ? r_pend_val : '0;
                    n_out_last   = 1'b1;
                    n_out_empty  = !r_pend_valid;
                    n_out_drop   = r_drop;
                    n_pend_valid = 1'b0;
                    n_cnt_a      = '0;
                    n_cnt_b      = '0;
                    n_drop       = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_drop       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_drop       <= n_drop;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_pend_val  <= n_pend_val;
        r_out_val   <= n_out_val;
        r_out_last  <= n_out_last;
        r_out_empty <= n_out_empty;
        r_out_drop  <= n_out_drop;
    end

    // no match is held outside a run
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_valid)
        else $error("held match outside a run");

    // pointers stay inside the loaded lists while comparing
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_i < r_cnt_a && r_j < r_cnt_b))
        else $error("walk pointer beyond list count");

    // counts never pass capacity
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(CAPACITY)) && (r_cnt_b <= CNT_W'(CAPACITY)))
        else $error("list count beyond capacity");

    // finishing a run leaves a last item and cleared counts
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && out_free) |=>
        (r_out_valid && r_out_last && r_cnt_a == '0 && r_cnt_b == '0 && !r_drop))
        else $error("run finished without a last item");

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_val)))
        else $error("stalled result changed");

endmodule

[tb/ssi_match_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the intersection unit, keeps its own copy of the
// two lists, predicts the results of every run and compares them in order.
module ssi_match_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ssi_in_if    i_in_mon,
    ssi_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    import ssi_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    empty_res;
        logic                    dropped;
    } t_match;

    logic signed [VAL_W-1:0] first_list  [CAPACITY];
    logic signed [VAL_W-1:0] second_list [CAPACITY];
    int                      first_len;
    int                      second_len;
    logic                    overflow_seen;
    t_match                  expected_matches [$];
    int                      fail_count = 0;

    assign o_fail_count = fail_count;

    // Append, drop on a full list, or walk both lists on a run
    function automatic void apply_item(t_op op, logic signed [VAL_W-1:0] value);
        int     a;
        int     b;
        int     found;
        t_match m;
        case (op)
            OP_LOAD_FIRST: begin
                if (first_len < CAPACITY) begin
                    first_list[first_len] = value;
                    first_len++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            OP_LOAD_SECOND: begin
                if (second_len < CAPACITY) begin
                    second_list[second_len] = value;
                    second_len++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            OP_RUN: begin
                a = 0;
                b = 0;
                found = 0;
                // advance the pointer at the smaller value, emit on a tie
                while (a < first_len && b < second_len) begin
                    if (first_list[a] < second_list[b]) begin
                        a++;
                    end else if (first_list[a] > second_list[b]) begin
                        b++;
                    end else begin
                        m.value     = first_list[a];
                        m.last      = 1'b0;
                        m.empty_res = 1'b0;
                        m.dropped   = overflow_seen;
                        expected_matches.push_back(m);
                        found++;
                        a++;
                        b++;
                    end
                end
                // mark the final result, or stand in one for an empty run
                if (found == 0) begin
                    m.value     = '0;
                    m.last      = 1'b1;
                    m.empty_res = 1'b1;
                    m.dropped   = overflow_seen;
                    expected_matches.push_back(m);
                end else begin
                    m = expected_matches.pop_back();
                    m.last = 1'b1;
                    expected_matches.push_back(m);
                end
                first_len     = 0;
                second_len    = 0;
                overflow_seen = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic signed [VAL_W-1:0] want,
                                        logic signed [VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Compare each result with the oldest expectation, then take in new items
    always @(posedge i_clk) begin : track
        t_match want;
        if (!i_rst_n) begin
            first_len     = 0;
            second_len    = 0;
            overflow_seen = 1'b0;
            expected_matches.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_matches.size() == 0) begin
                    $error("unexpected result: common_value %0d",
                           i_out_mon.common_value);
                    fail_count++;
                end else begin
                    want = expected_matches.pop_front();
                    check_field("common_value", want.value, i_out_mon.common_value);
                    check_field("last", VAL_W'(want.last), VAL_W'(i_out_mon.last));
                    check_field("empty_res", VAL_W'(want.empty_res),
                                VAL_W'(i_out_mon.empty_res));
                    check_field("dropped", VAL_W'(want.dropped),
                                VAL_W'(i_out_mon.dropped));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                apply_item(t_op'(i_in_mon.op), i_in_mon.value);
            end
        end
        o_pending <= expected_matches.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ssi_pkg::*;

    localparam int              IDLE_LIMIT   = 2000;
    localparam int              DRAIN_CYCLES = 200;
    localparam int              ITEM_TARGET  = 380;
    localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

    typedef int t_int_q [$];

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct  = 28;
    int   recv_stall_pct = 46;
    int   items_sent     = 0;
    int   quiet_cycles   = 0;
    int   fail_count;
    int   pending_matches;

    ssi_in_if  in_ch ();
    ssi_out_if out_ch ();

    sorted_set_intersection_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ssi_match_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_matches)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result channel at random
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic signed [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op    <= op;
        in_ch.value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (op != OP_UNUSED) items_sent++;
    endtask

    // Hold off the sender until every expected result has come out
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_matches != 0) @(posedge i_clk);
    endtask

    function automatic t_int_q fill_list(int n, t_int_q pool, bit sorted);
        t_int_q vals;
        repeat (n) vals.push_back(pool[$urandom_range(pool.size() - 1)]);
        if (sorted) vals.sort();
        return vals;
    endfunction

    // Load both lists with the loads of the two interleaved at random
    task automatic load_lists(input t_int_q first_vals, input t_int_q second_vals);
        while (first_vals.size() > 0 || second_vals.size() > 0) begin
            if (second_vals.size() == 0 || (first_vals.size() > 0 && $urandom_range(1))) begin
                send_item(OP_LOAD_FIRST, first_vals.pop_front());
            end else begin
                send_item(OP_LOAD_SECOND, second_vals.pop_front());
            end
        end
    endtask

    initial begin : stimulus
        t_int_q pool;
        int     n_first;
        int     n_second;
        int     kind;
        int     seq_idx;
        bit     small_range;

        in_ch.valid <= 1'b0;
        in_ch.op    <= OP_LOAD_FIRST;
        in_ch.value <= '0;
        i_rst_n     <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // run on two empty lists
        send_item(OP_RUN, '0);
        // extremes of the value range on both lists
        send_item(OP_LOAD_FIRST, 32'sh8000_0000);
        send_item(OP_LOAD_FIRST, -1);
        send_item(OP_LOAD_FIRST, 0);
        send_item(OP_LOAD_FIRST, 1);
        send_item(OP_LOAD_FIRST, 32'sh7FFF_FFFF);
        send_item(OP_LOAD_SECOND, 32'sh8000_0000);
        send_item(OP_LOAD_SECOND, 0);
        send_item(OP_LOAD_SECOND, 32'sh7FFF_FFFF);
        send_item(OP_RUN, -1);
        // unused opcode must leave no trace
        send_item(OP_UNUSED, 32'sh5A5A_A5A5);
        // unsorted lists walk as loaded
        send_item(OP_LOAD_FIRST, 5);
        send_item(OP_LOAD_FIRST, 1);
        send_item(OP_LOAD_SECOND, 1);
        send_item(OP_LOAD_SECOND, 5);
        send_item(OP_RUN, 0);
        // repeated values match pair by pair
        send_item(OP_LOAD_FIRST, 2);
        send_item(OP_LOAD_FIRST, 2);
        send_item(OP_LOAD_SECOND, 2);
        send_item(OP_LOAD_SECOND, 2);
        send_item(OP_LOAD_SECOND, 2);
        send_item(OP_RUN, 0);
        wait_for_results();

        seq_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            // swap idling between the two sides, then drop it altogether
            if (items_sent < ITEM_TARGET / 3) begin
                send_idle_pct  = 28;
                recv_stall_pct = 46;
            end else if (items_sent < 2 * ITEM_TARGET / 3) begin
                send_idle_pct  = 46;
                recv_stall_pct = 28;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end

            // draw values from a shared pool so that the lists overlap
            small_range = $urandom_range(1);
            pool.delete();
            repeat (24) begin
                pool.push_back(small_range ? int'($urandom_range(40)) - 20 : int'($urandom));
            end
            n_first  = $urandom_range(12);
            n_second = $urandom_range(12);
            if ($urandom_range(9) == 0) n_first = $urandom_range(19, 16);
            if ($urandom_range(9) == 0) n_second = $urandom_range(19, 16);

            kind = $urandom_range(99);
            if (kind < 75) begin
                load_lists(fill_list(n_first, pool, 1'b1), fill_list(n_second, pool, 1'b1));
                send_item(OP_RUN, $urandom);
            end else if (kind < 90) begin
                load_lists(fill_list(n_first, pool, 1'b0), fill_list(n_second, pool, 1'b0));
                send_item(OP_RUN, $urandom);
            end else begin
                // noise: any opcode, any value
                repeat ($urandom_range(6, 1)) begin
                    send_item(OP_W'($urandom_range(OP_UNUSED)), $urandom);
                end
                if ($urandom_range(1)) send_item(OP_RUN, $urandom);
            end

            if (seq_idx % 8 == 7) wait_for_results();
            seq_idx++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_matches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
